>>> src/segrc_pkg.sv
// Shared widths, types and corner/side codes for the segment-rectangle collision test.
`timescale 1ns / 1ps
`default_nettype none
package segrc_pkg;

	localparam int COORD_W    = 16;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int MULT_W     = 2 * DIFF_W;
	localparam int SUM_W      = MULT_W + 1;
	localparam int PIPE_DEPTH = 5;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

	localparam int NUM_SIDES = 4;
	localparam int NUM_CNR   = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [MULT_W-1:0]  mult_t;
	typedef logic [1:0]                cnr_idx_t;
	typedef logic [1:0]                side_idx_t;

	localparam cnr_idx_t CNR_LL = 2'd0;
	localparam cnr_idx_t CNR_LH = 2'd1;
	localparam cnr_idx_t CNR_HL = 2'd2;
	localparam cnr_idx_t CNR_HH = 2'd3;

	localparam side_idx_t SIDE_L = 2'd0;
	localparam side_idx_t SIDE_B = 2'd1;
	localparam side_idx_t SIDE_R = 2'd2;
	localparam side_idx_t SIDE_T = 2'd3;

	localparam cnr_idx_t SIDE_P3 [NUM_SIDES] = '{CNR_LL, CNR_LL, CNR_HL, CNR_LH};
	localparam cnr_idx_t SIDE_P4 [NUM_SIDES] = '{CNR_LH, CNR_HL, CNR_HH, CNR_HH};

	typedef struct packed {
		diff_t                  dx;
		diff_t                  dy;
		diff_t                  exl;
		diff_t                  exh;
		diff_t                  eyl;
		diff_t                  eyh;
		logic                   in_box;
		logic [NUM_SIDES-1:0]   coll;
		logic [NUM_SIDES-1:0]   strad;
	} prep_t;

	typedef struct packed {
		mult_t                  cx_l;
		mult_t                  cx_h;
		mult_t                  cy_l;
		mult_t                  cy_h;
		mult_t                  dt_xl;
		mult_t                  dt_xh;
		mult_t                  dt_yl;
		mult_t                  dt_yh;
		mult_t                  sq_x;
		mult_t                  sq_y;
		logic                   in_box;
		logic [NUM_SIDES-1:0]   coll;
		logic [NUM_SIDES-1:0]   strad;
	} prod_set_t;

endpackage
`default_nettype wire

>>> src/segrc_if.sv
// Query and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface segrc_in_if import segrc_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t seg_ax;
	coord_t seg_ay;
	coord_t seg_bx;
	coord_t seg_by;
	coord_t box_ax;
	coord_t box_ay;
	coord_t box_bx;
	coord_t box_by;

	modport source (output valid, seg_ax, seg_ay, seg_bx, seg_by,
		box_ax, box_ay, box_bx, box_by, input ready);
	modport sink (input valid, seg_ax, seg_ay, seg_bx, seg_by,
		box_ax, box_ay, box_bx, box_by, output ready);
endinterface

interface segrc_out_if;
	logic valid;
	logic ready;
	logic collides;

	modport source (output valid, collides, input ready);
	modport sink (input valid, collides, output ready);
endinterface
`default_nettype wire

>>> src/segrc_prep.sv
// Corner sort, coordinate differences and axis-aligned side sign flags (stages 1 and 2).
`timescale 1ns / 1ps
`default_nettype none
module segrc_prep import segrc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	segrc_in_if.sink        query,
	output logic            prep_valid,
	input  wire logic       prep_ready,
	output prep_t           prep
);

	logic   v_s1, v_s2;
	logic   rdy_s1, rdy_s2;
	coord_t ax_s1, ay_s1, bx_s1, by_s1, lx_s1, ly_s1, hx_s1, hy_s1;
	prep_t  prep_s2;
	prep_t  prep_d;

	logic                 w_pos, h_pos, in_a, in_b;
	logic [NUM_SIDES-1:0] pos_a, pos_b, zero_a, zero_b;

	assign rdy_s2      = !v_s2 || prep_ready;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign query.ready = rdy_s1;
	assign prep_valid  = v_s2;
	assign prep        = prep_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= query.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// sort corners on the way in
	always_ff @(posedge clk) begin
		if (rdy_s1 && query.valid) begin
			ax_s1 <= query.seg_ax;
			ay_s1 <= query.seg_ay;
			bx_s1 <= query.seg_bx;
			by_s1 <= query.seg_by;
			lx_s1 <= (query.box_ax > query.box_bx) ? query.box_bx : query.box_ax;
			hx_s1 <= (query.box_ax > query.box_bx) ? query.box_ax : query.box_bx;
			ly_s1 <= (query.box_ay > query.box_by) ? query.box_by : query.box_ay;
			hy_s1 <= (query.box_ay > query.box_by) ? query.box_ay : query.box_by;
		end
	end

	always_comb begin
		w_pos = hx_s1 > lx_s1;
		h_pos = hy_s1 > ly_s1;
		in_a  = (ax_s1 >= lx_s1) && (ax_s1 <= hx_s1) && (ay_s1 >= ly_s1) && (ay_s1 <= hy_s1);
		in_b  = (bx_s1 >= lx_s1) && (bx_s1 <= hx_s1) && (by_s1 >= ly_s1) && (by_s1 <= hy_s1);

		pos_a[SIDE_L]  = h_pos && (ax_s1 > lx_s1);
		zero_a[SIDE_L] = !h_pos || (ax_s1 == lx_s1);
		pos_b[SIDE_L]  = h_pos && (bx_s1 > lx_s1);
		zero_b[SIDE_L] = !h_pos || (bx_s1 == lx_s1);

		pos_a[SIDE_B]  = w_pos && (ay_s1 < ly_s1);
		zero_a[SIDE_B] = !w_pos || (ay_s1 == ly_s1);
		pos_b[SIDE_B]  = w_pos && (by_s1 < ly_s1);
		zero_b[SIDE_B] = !w_pos || (by_s1 == ly_s1);

		pos_a[SIDE_R]  = h_pos && (ax_s1 > hx_s1);
		zero_a[SIDE_R] = !h_pos || (ax_s1 == hx_s1);
		pos_b[SIDE_R]  = h_pos && (bx_s1 > hx_s1);
		zero_b[SIDE_R] = !h_pos || (bx_s1 == hx_s1);

		pos_a[SIDE_T]  = w_pos && (ay_s1 < hy_s1);
		zero_a[SIDE_T] = !w_pos || (ay_s1 == hy_s1);
		pos_b[SIDE_T]  = w_pos && (by_s1 < hy_s1);
		zero_b[SIDE_T] = !w_pos || (by_s1 == hy_s1);

		prep_d.dx     = DIFF_W'(bx_s1) - DIFF_W'(ax_s1);
		prep_d.dy     = DIFF_W'(by_s1) - DIFF_W'(ay_s1);
		prep_d.exl    = DIFF_W'(lx_s1) - DIFF_W'(ax_s1);
		prep_d.exh    = DIFF_W'(hx_s1) - DIFF_W'(ax_s1);
		prep_d.eyl    = DIFF_W'(ly_s1) - DIFF_W'(ay_s1);
		prep_d.eyh    = DIFF_W'(hy_s1) - DIFF_W'(ay_s1);
		prep_d.in_box = in_a || in_b;
		prep_d.coll   = zero_a & zero_b;
		prep_d.strad  = pos_a ^ pos_b;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			prep_s2 <= prep_d;
		end
	end

endmodule
`default_nettype wire

>>> src/segrc_mul.sv
// Cross and dot product terms (stage 3).
`timescale 1ns / 1ps
`default_nettype none
module segrc_mul import segrc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       prep_valid,
	output logic            prep_ready,
	input  wire prep_t      prep,
	output logic            prod_valid,
	input  wire logic       prod_ready,
	output prod_set_t       prod
);

	logic      v_s3;
	logic      rdy_s3;
	prod_set_t prod_s3;
	diff_t     dx, dy, exl, exh, eyl, eyh;

	assign dx  = prep.dx;
	assign dy  = prep.dy;
	assign exl = prep.exl;
	assign exh = prep.exh;
	assign eyl = prep.eyl;
	assign eyh = prep.eyh;

	assign rdy_s3     = !v_s3 || prod_ready;
	assign prep_ready = rdy_s3;
	assign prod_valid = v_s3;
	assign prod       = prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= prep_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && prep_valid) begin
			prod_s3.cx_l   <= MULT_W'(dy) * MULT_W'(exl);
			prod_s3.cx_h   <= MULT_W'(dy) * MULT_W'(exh);
			prod_s3.cy_l   <= MULT_W'(dx) * MULT_W'(eyl);
			prod_s3.cy_h   <= MULT_W'(dx) * MULT_W'(eyh);
			prod_s3.dt_xl  <= MULT_W'(dx) * MULT_W'(exl);
			prod_s3.dt_xh  <= MULT_W'(dx) * MULT_W'(exh);
			prod_s3.dt_yl  <= MULT_W'(dy) * MULT_W'(eyl);
			prod_s3.dt_yh  <= MULT_W'(dy) * MULT_W'(eyh);
			prod_s3.sq_x   <= MULT_W'(dx) * MULT_W'(dx);
			prod_s3.sq_y   <= MULT_W'(dy) * MULT_W'(dy);
			prod_s3.in_box <= prep.in_box;
			prod_s3.coll   <= prep.coll;
			prod_s3.strad  <= prep.strad;
		end
	end

endmodule
`default_nettype wire

>>> src/segrc_eval.sv
// Corner cross and dot sums (stage 4) and the side decision into the result register (stage 5).
`timescale 1ns / 1ps
`default_nettype none
module segrc_eval import segrc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       prod_valid,
	output logic            prod_ready,
	input  wire prod_set_t  prod,
	segrc_out_if.source     result
);

	logic v_s4, v_s5;
	logic rdy_s4, rdy_s5;

	mult_t cx_l, cx_h, cy_l, cy_h, dt_xl, dt_xh, dt_yl, dt_yh, sq_x, sq_y;

	logic signed [SUM_W-1:0] cr_d  [NUM_CNR];
	logic signed [SUM_W-1:0] dot_d [NUM_CNR];
	logic signed [SUM_W-1:0] cr_s4  [NUM_CNR];
	logic signed [SUM_W-1:0] dot_s4 [NUM_CNR];
	logic signed [SUM_W-1:0] sq_s4;
	logic                    in_box_s4;
	logic [NUM_SIDES-1:0]    coll_s4, strad_s4;
	logic                    collides_s5;

	logic [NUM_CNR-1:0]   cpos, tneg, tgt;
	logic [NUM_SIDES-1:0] side_hit;
	logic                 hit_d;

	assign cx_l  = prod.cx_l;
	assign cx_h  = prod.cx_h;
	assign cy_l  = prod.cy_l;
	assign cy_h  = prod.cy_h;
	assign dt_xl = prod.dt_xl;
	assign dt_xh = prod.dt_xh;
	assign dt_yl = prod.dt_yl;
	assign dt_yh = prod.dt_yh;
	assign sq_x  = prod.sq_x;
	assign sq_y  = prod.sq_y;

	assign rdy_s5          = !v_s5 || result.ready;
	assign rdy_s4          = !v_s4 || rdy_s5;
	assign prod_ready      = rdy_s4;
	assign result.valid    = v_s5;
	assign result.collides = collides_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) begin
				v_s4 <= prod_valid;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_comb begin
		cr_d[CNR_LL]  = SUM_W'(cx_l) - SUM_W'(cy_l);
		cr_d[CNR_LH]  = SUM_W'(cx_l) - SUM_W'(cy_h);
		cr_d[CNR_HL]  = SUM_W'(cx_h) - SUM_W'(cy_l);
		cr_d[CNR_HH]  = SUM_W'(cx_h) - SUM_W'(cy_h);
		dot_d[CNR_LL] = SUM_W'(dt_xl) + SUM_W'(dt_yl);
		dot_d[CNR_LH] = SUM_W'(dt_xl) + SUM_W'(dt_yh);
		dot_d[CNR_HL] = SUM_W'(dt_xh) + SUM_W'(dt_yl);
		dot_d[CNR_HH] = SUM_W'(dt_xh) + SUM_W'(dt_yh);
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && prod_valid) begin
			for (int c = 0; c < NUM_CNR; c++) begin
				cr_s4[c]  <= cr_d[c];
				dot_s4[c] <= dot_d[c];
			end
			sq_s4     <= SUM_W'(sq_x) + SUM_W'(sq_y);
			in_box_s4 <= prod.in_box;
			coll_s4   <= prod.coll;
			strad_s4  <= prod.strad;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CNR; c++) begin
			cpos[c] = !cr_s4[c][SUM_W-1] && (cr_s4[c] != '0);
			tneg[c] = dot_s4[c][SUM_W-1];
			tgt[c]  = dot_s4[c] > sq_s4;
		end
		for (int k = 0; k < NUM_SIDES; k++) begin
			if (coll_s4[k]) begin
				side_hit[k] = !((tneg[SIDE_P3[k]] && tneg[SIDE_P4[k]])
					|| (tgt[SIDE_P3[k]] && tgt[SIDE_P4[k]]));
			end else if (strad_s4[k]) begin
				side_hit[k] = cpos[SIDE_P3[k]] ^ cpos[SIDE_P4[k]];
			end else begin
				side_hit[k] = 1'b0;
			end
		end
		hit_d = in_box_s4 || (|side_hit);
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			collides_s5 <= hit_d;
		end
	end

endmodule
`default_nettype wire

>>> src/segment_rectangle_collision.sv
// Top level of the segment versus axis-aligned rectangle collision test.
//
//   channel   role    payload                                   handshake
//   query     sink    seg_ax..seg_by, box_ax..box_by (s16 each) valid/ready
//   result    source  collides (1 bit)                          valid/ready
//
// Five register stages: corner sort, differences and side flags, products,
// sums, decision. One item per cycle unless the result stalls. Each stage
// holds its item while the next one is full, so bubbles close up under a
// stall. Reset clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module segment_rectangle_collision import segrc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	segrc_in_if.sink        query,
	segrc_out_if.source     result
);

	logic      prep_valid, prep_ready;
	prep_t     prep;
	logic      prod_valid, prod_ready;
	prod_set_t prod;

	segrc_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.query      (query),
		.prep_valid (prep_valid),
		.prep_ready (prep_ready),
		.prep       (prep)
	);

	segrc_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.prep_valid (prep_valid),
		.prep_ready (prep_ready),
		.prep       (prep),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod)
	);

	segrc_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod),
		.result     (result)
	);

endmodule
`default_nettype wire

>>> src/segrc_checker.sv
// Port-level checks for the collision test, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module segrc_checker import segrc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic query_valid,
	input wire logic query_ready,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic result_collides
);

	logic [CNT_W-1:0] inflight_q;
	logic             q_acc, r_acc;

	assign q_acc = query_valid && query_ready;
	assign r_acc = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (q_acc && !r_acc) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (!q_acc && r_acc) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped under stall");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_collides))
		else $error("result changed under stall");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!query_ready |-> result_valid && !result_ready)
		else $error("query stalled while output is free");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> inflight_q != '0)
		else $error("result with no item in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(PIPE_DEPTH))
		else $error("more items in flight than stages");

endmodule

bind segment_rectangle_collision segrc_checker u_segrc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.query_valid     (query.valid),
	.query_ready     (query.ready),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_collides (result.collides)
);
`default_nettype wire
